FILE: design/cmg_pkg.sv
// Shared constants and helper functions for the calendar month grid unit.
`default_nettype none
package cmg_pkg;

    localparam int GRID_CELLS   = 42;
    localparam int CELL_IDX_W   = 6;
    localparam int YEAR_W       = 14;
    localparam int MONTH_W      = 4;
    localparam int DAY_W        = 5;
    localparam int KIND_W       = 2;
    localparam int YY_W         = 15;
    localparam int CENT_W       = 8;

    // floor(yy / 100) == (yy * 5243) >> 19 for yy < 43690
    localparam int RECIP_100    = 5243;
    localparam int RECIP_SHIFT  = 19;
    localparam int PROD_W       = 28;

    localparam logic [KIND_W-1:0] KIND_PREV = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CUR  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NEXT = 2'd2;

    localparam logic [CELL_IDX_W-1:0] LAST_IDX = CELL_IDX_W'(GRID_CELLS - 1);
    localparam logic [DAY_W-1:0]      MAX_DAY  = 5'd31;

    // Weekday offset of the 1st of each month, January first.
    function automatic logic [2:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [2:0] off;
        case (m)
            4'd1:    off = 3'd0;
            4'd2:    off = 3'd3;
            4'd3:    off = 3'd2;
            4'd4:    off = 3'd5;
            4'd5:    off = 3'd0;
            4'd6:    off = 3'd3;
            4'd7:    off = 3'd5;
            4'd8:    off = 3'd1;
            4'd9:    off = 3'd4;
            4'd10:   off = 3'd6;
            4'd11:   off = 3'd2;
            4'd12:   off = 3'd4;
            default: off = 3'd0;
        endcase
        return off;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

FILE: design/calendar_month_grid_unit.sv
// Calendar month grid unit: turns a year and month into the 42 cells of a page.
//
// Each request (year, month) yields 42 results, one per cell of a six-week page,
// row-major from Sunday: trailing days of the previous month, the days of the
// month, then the next month from 1. The generator drives one cell per cycle on
// the result port while m_ready is high; the next page's first cell follows the
// previous page's last cell with no gap when its request is already in stage B.
// Three setup stages (input, century quotient, weekday sum) run ahead of the
// generator, which loads the first cell from stage B, and up to three further
// requests are buffered while a page is being generated.
// Month 0 is taken as January and months above 12 as December.
`default_nettype none
module calendar_month_grid_unit
    import cmg_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [YEAR_W-1:0]      s_year,
    input  wire logic [MONTH_W-1:0]     s_month,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [CELL_IDX_W-1:0]       m_cell_index,
    output logic [DAY_W-1:0]            m_day_number,
    output logic [KIND_W-1:0]           m_cell_kind,
    output logic                        m_last_cell
);

    // ---------------- input stage ----------------
    logic                 in_vld_reg;
    logic [YEAR_W-1:0]    in_year_reg;
    logic [MONTH_W-1:0]   in_month_reg;
    logic [MONTH_W-1:0]   month_clamped;

    // ---------------- stage A: century quotient ----------------
    logic                 a_vld_reg;
    logic [YY_W-1:0]      a_yy_reg;
    logic [CENT_W-1:0]    a_q_reg;
    logic [MONTH_W-1:0]   a_month_reg;
    logic                 a_div4_reg;
    logic [YY_W-1:0]      yy_next;
    logic [PROD_W-1:0]    prod;

    // ---------------- stage B: weekday sum, month lengths ----------------
    logic                 b_vld_reg;
    logic [YY_W-1:0]      b_sum_reg;
    logic [DAY_W-1:0]     b_cur_len_reg;
    logic [DAY_W-1:0]     b_prev_len_reg;
    logic [YY_W-1:0]      sum_next;
    logic [YY_W-1:0]      cent_prod;
    logic [6:0]           rem100;
    logic                 early;
    logic                 cent_year;
    logic                 quad_cent;
    logic                 leap;
    logic [CENT_W-1:0]    q_plus1;

    // ---------------- generator / output ----------------
    logic [CELL_IDX_W-1:0] idx_reg,   idx_next;
    logic [DAY_W-1:0]      day_reg,   day_next;
    logic [KIND_W-1:0]     kind_reg,  kind_next;
    logic                  last_reg,  last_next;
    logic                  out_vld_reg, out_vld_next;
    logic [2:0]            start_reg, start_next;
    logic [DAY_W-1:0]      cur_len_reg, cur_len_next;

    logic [5:0]            oct_sum;
    logic [3:0]            oct_fold;
    logic [2:0]            weekday;

    logic gen_load, gen_step;
    logic b_ready, a_ready;

    // handshake chain
    assign gen_load = b_vld_reg && (!out_vld_reg || (m_ready && last_reg));
    assign gen_step = out_vld_reg && m_ready && !last_reg;
    assign b_ready  = !b_vld_reg || gen_load;
    assign a_ready  = !a_vld_reg || b_ready;
    assign s_ready  = !in_vld_reg || a_ready;

    assign month_clamped = (s_month == 4'd0) ? 4'd1 :
                           (s_month > 4'd12) ? 4'd12 : s_month;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_year_reg  <= s_year;
            in_month_reg <= month_clamped;
        end
    end

    // stage A
    assign yy_next = YY_W'(in_year_reg) + YY_W'(400)
                   - ((in_month_reg < 4'd3) ? YY_W'(1) : YY_W'(0));
    assign prod    = PROD_W'(yy_next) * PROD_W'(RECIP_100);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (a_ready) begin
            a_vld_reg <= in_vld_reg;
        end
        if (a_ready && in_vld_reg) begin
            a_yy_reg    <= yy_next;
            a_q_reg     <= prod[RECIP_SHIFT +: CENT_W];
            a_month_reg <= in_month_reg;
            a_div4_reg  <= (in_year_reg[1:0] == 2'b00);
        end
    end

    // stage B
    assign early     = (a_month_reg < 4'd3);
    assign cent_prod = YY_W'(a_q_reg) * YY_W'(100);
    assign rem100    = 7'(a_yy_reg - cent_prod);
    assign q_plus1   = a_q_reg + CENT_W'(1);
    // yy is year+399 in Jan/Feb and year+400 otherwise
    assign cent_year = early ? (rem100 == 7'd99) : (rem100 == 7'd0);
    assign quad_cent = early ? (q_plus1[1:0] == 2'b00) : (a_q_reg[1:0] == 2'b00);
    assign leap      = (a_div4_reg && !cent_year) || (cent_year && quad_cent);

    assign sum_next = a_yy_reg + (a_yy_reg >> 2) - YY_W'(a_q_reg)
                    + YY_W'(a_q_reg >> 2) + YY_W'(month_offset(a_month_reg))
                    + YY_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (b_ready) begin
            b_vld_reg <= a_vld_reg;
        end
        if (b_ready && a_vld_reg) begin
            b_sum_reg      <= sum_next;
            b_cur_len_reg  <= month_len(a_month_reg, leap);
            b_prev_len_reg <= (a_month_reg == 4'd1) ? MAX_DAY
                              : month_len(a_month_reg - 4'd1, leap);
        end
    end

    // sum mod 7: octal digits fold since 8 == 1 (mod 7)
    assign oct_sum  = 6'(b_sum_reg[14:12]) + 6'(b_sum_reg[11:9]) + 6'(b_sum_reg[8:6])
                    + 6'(b_sum_reg[5:3]) + 6'(b_sum_reg[2:0]);
    assign oct_fold = 4'(oct_sum[5:3]) + 4'(oct_sum[2:0]);
    assign weekday  = (oct_fold >= 4'd7) ? 3'(oct_fold - 4'd7) : oct_fold[2:0];

    always_comb begin
        idx_next     = idx_reg;
        day_next     = day_reg;
        kind_next    = kind_reg;
        last_next    = last_reg;
        out_vld_next = out_vld_reg;
        start_next   = start_reg;
        cur_len_next = cur_len_reg;
        if (gen_load) begin
            out_vld_next = 1'b1;
            idx_next     = '0;
            last_next    = (LAST_IDX == '0);
            start_next   = weekday;
            cur_len_next = b_cur_len_reg;
            if (weekday == 3'd0) begin
                kind_next = KIND_CUR;
                day_next  = 5'd1;
            end else begin
                kind_next = KIND_PREV;
                day_next  = b_prev_len_reg - DAY_W'(weekday) + 5'd1;
            end
        end else if (gen_step) begin
            idx_next  = idx_reg + CELL_IDX_W'(1);
            last_next = (idx_next == LAST_IDX);
            case (kind_reg)
                KIND_PREV: begin
                    if (idx_next == CELL_IDX_W'(start_reg)) begin
                        kind_next = KIND_CUR;
                        day_next  = 5'd1;
                    end else begin
                        day_next = day_reg + 5'd1;
                    end
                end
                KIND_CUR: begin
                    if (day_reg == cur_len_reg) begin
                        kind_next = KIND_NEXT;
                        day_next  = 5'd1;
                    end else begin
                        day_next = day_reg + 5'd1;
                    end
                end
                default: begin
                    // next month day number saturates at 31
                    if (day_reg != MAX_DAY) begin
                        day_next = day_reg + 5'd1;
                    end
                end
            endcase
        end else if (out_vld_reg && m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
        end
        idx_reg     <= idx_next;
        day_reg     <= day_next;
        kind_reg    <= kind_next;
        last_reg    <= last_next;
        start_reg   <= start_next;
        cur_len_reg <= cur_len_next;
    end

    assign m_valid      = out_vld_reg;
    assign m_cell_index = idx_reg;
    assign m_day_number = day_reg;
    assign m_cell_kind  = kind_reg;
    assign m_last_cell  = last_reg;

endmodule
`default_nettype wire
